FILE: rtl/npcm_pkg.sv
// Package for the nearest palette color mapper.
// Holds the widths, operation codes and the item record handed along the cell chain.
// No dependencies.
package npcm_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int CHAN_W        = 8;
	localparam int INDEX_W       = 8;
	localparam int COUNT_W       = 9;
	localparam int DIST_W        = 18;
	localparam int LATENCY       = 2 * PALETTE_DEPTH + 1;

	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);
	localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(PALETTE_DEPTH);
	localparam logic [DIST_W-1:0]  DIST_MAX    = DIST_W'(195075);

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_MAP   = 1'b1
	} op_t;

	typedef struct packed {
		logic                valid;
		op_t                 op;
		logic [INDEX_W-1:0]  entry_index;
		logic [CHAN_W-1:0]   red;
		logic [CHAN_W-1:0]   green;
		logic [CHAN_W-1:0]   blue;
		logic [INDEX_W-1:0]  best_index;
		logic [DIST_W-1:0]   best_dist;
	} item_t;

endpackage

FILE: rtl/nearest_palette_color_mapper_unit.sv
// Nearest palette color mapper: a chain of PALETTE_DEPTH cells, one palette entry each.
// Every item (write or pixel) passes the stages of every cell; one item enters per cycle.
// done is registered from the last cell's output and rises for one cycle per pixel item.
// busy stays low: the chain is fully pipelined, not built on any loop.
// The receiver cannot stall; each result is taken at the edge that ends its done cycle.
// Reset clears the item registers and sets search_count_q to 256; entries stay undefined.
module nearest_palette_color_mapper_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            op,
	input  logic [npcm_pkg::INDEX_W-1:0]    entry_index,
	input  logic [npcm_pkg::CHAN_W-1:0]     red,
	input  logic [npcm_pkg::CHAN_W-1:0]     green,
	input  logic [npcm_pkg::CHAN_W-1:0]     blue,
	input  logic                            cfg_wr_en,
	input  logic [npcm_pkg::COUNT_W-1:0]    cfg_wr_data,
	output logic                            done,
	output logic [npcm_pkg::INDEX_W-1:0]    color_index,
	output logic [npcm_pkg::DIST_W-1:0]     distance
);

	logic [npcm_pkg::COUNT_W-1:0] search_count_q;
	npcm_pkg::item_t              head;
	npcm_pkg::item_t              chain [npcm_pkg::PALETTE_DEPTH+1];
	npcm_pkg::item_t              tail;
	logic                         done_q;
	logic [npcm_pkg::INDEX_W-1:0] color_index_q;
	logic [npcm_pkg::DIST_W-1:0]  distance_q;

	assign busy = 1'b0;

	// hold the clamped search count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_count_q <= (npcm_pkg::COUNT_RESET > npcm_pkg::COUNT_MAX) ?
				npcm_pkg::COUNT_MAX : npcm_pkg::COUNT_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_wr_data > npcm_pkg::COUNT_MAX) begin
				search_count_q <= npcm_pkg::COUNT_MAX;
			end else if (cfg_wr_data == '0) begin
				search_count_q <= npcm_pkg::COUNT_W'(1);
			end else begin
				search_count_q <= cfg_wr_data;
			end
		end
	end

	always_comb begin
		head.valid       = start && !busy;
		head.op          = npcm_pkg::op_t'(op);
		head.entry_index = entry_index;
		head.red         = red;
		head.green       = green;
		head.blue        = blue;
		head.best_index  = '0;
		head.best_dist   = '1;
	end

	assign chain[0] = head;

	for (genvar g = 0; g < npcm_pkg::PALETTE_DEPTH; g++) begin : g_cell
		npcm_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cell_idx     (npcm_pkg::INDEX_W'(g)),
			.search_count (search_count_q),
			.item_in      (chain[g]),
			.item_out     (chain[g+1])
		);
	end

	assign tail = chain[npcm_pkg::PALETTE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tail.valid && tail.op == npcm_pkg::OP_MAP;
		end
	end

	always_ff @(posedge clk) begin
		color_index_q <= tail.best_index;
		distance_q    <= tail.best_dist;
	end

	assign done        = done_q;
	assign color_index = color_index_q;
	assign distance    = distance_q;

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> distance <= npcm_pkg::DIST_MAX)
		else $error("distance out of range");

	a_index_searched: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> {1'b0, color_index} < search_count_q)
		else $error("color index beyond searched entries");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		search_count_q != '0 && search_count_q <= npcm_pkg::COUNT_MAX)
		else $error("search count out of range");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && op == npcm_pkg::OP_MAP, npcm_pkg::LATENCY))
		else $error("result without matching pixel item");

endmodule

FILE: rtl/npcm_dist.sv
// Squared RGB distance between a stored palette color and a pixel.
// Uses npcm_pkg for the channel and distance widths.
module npcm_dist (
	input  logic [npcm_pkg::CHAN_W-1:0] red_a,
	input  logic [npcm_pkg::CHAN_W-1:0] green_a,
	input  logic [npcm_pkg::CHAN_W-1:0] blue_a,
	input  logic [npcm_pkg::CHAN_W-1:0] red_b,
	input  logic [npcm_pkg::CHAN_W-1:0] green_b,
	input  logic [npcm_pkg::CHAN_W-1:0] blue_b,
	output logic [npcm_pkg::DIST_W-1:0] sq_sum
);

	logic [npcm_pkg::CHAN_W-1:0]   diff_r, diff_g, diff_b;
	logic [2*npcm_pkg::CHAN_W-1:0] sq_r, sq_g, sq_b;

	always_comb begin
		diff_r = (red_a   >= red_b)   ? red_a   - red_b   : red_b   - red_a;
		diff_g = (green_a >= green_b) ? green_a - green_b : green_b - green_a;
		diff_b = (blue_a  >= blue_b)  ? blue_a  - blue_b  : blue_b  - blue_a;
		sq_r   = diff_r * diff_r;
		sq_g   = diff_g * diff_g;
		sq_b   = diff_b * diff_b;
		sq_sum = npcm_pkg::DIST_W'(sq_r) + npcm_pkg::DIST_W'(sq_g) + npcm_pkg::DIST_W'(sq_b);
	end

endmodule

FILE: rtl/npcm_cell.sv
// One palette cell: holds one entry, measures the passing pixel, keeps the nearer best.
// Two stages: distance, then compare. Uses npcm_pkg and npcm_dist.
module npcm_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [npcm_pkg::INDEX_W-1:0]   cell_idx,
	input  logic [npcm_pkg::COUNT_W-1:0]   search_count,
	input  npcm_pkg::item_t                item_in,
	output npcm_pkg::item_t                item_out
);

	logic [npcm_pkg::CHAN_W-1:0] entry_r_q, entry_g_q, entry_b_q;
	logic [npcm_pkg::DIST_W-1:0] cur_dist;
	logic [npcm_pkg::DIST_W-1:0] dist_s1;
	npcm_pkg::item_t             item_s1;
	npcm_pkg::item_t             item_s2;
	npcm_pkg::item_t             next_s2;
	logic                        active;

	npcm_dist u_dist (
		.red_a   (entry_r_q),
		.green_a (entry_g_q),
		.blue_a  (entry_b_q),
		.red_b   (item_in.red),
		.green_b (item_in.green),
		.blue_b  (item_in.blue),
		.sq_sum  (cur_dist)
	);

	// latch the entry when a write for this cell passes
	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.op == npcm_pkg::OP_WRITE &&
				item_in.entry_index == cell_idx) begin
			entry_r_q <= item_in.red;
			entry_g_q <= item_in.green;
			entry_b_q <= item_in.blue;
		end
	end

	always_comb begin
		active  = {1'b0, cell_idx} < search_count;
		next_s2 = item_s1;
		if (item_s1.valid && item_s1.op == npcm_pkg::OP_MAP && active &&
				dist_s1 < item_s1.best_dist) begin
			next_s2.best_dist  = dist_s1;
			next_s2.best_index = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_s1 <= '0;
			item_s1 <= '0;
			item_s2 <= '0;
		end else begin
			dist_s1 <= cur_dist;
			item_s1 <= item_in;
			item_s2 <= next_s2;
		end
	end

	assign item_out = item_s2;

endmodule

FILE: sim/nearest_palette_color_mapper_unit_test.sv
`timescale 1ns / 1ps
// Testbench for nearest_palette_color_mapper_unit: a directed table, then random phases
// over several palette counts, each checked against a predictor of the nearest-color search.
// Depends on npcm_pkg and the mapper RTL.
module nearest_palette_color_mapper_unit_test;

	localparam int TIMEOUT_CYCLES = 400000;
	localparam int PHASE_ITEMS    = 70;
	localparam int NUM_PHASES     = 8;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                     kind;
		npcm_pkg::op_t                 op_code;
		logic [npcm_pkg::INDEX_W-1:0]  idx;
		logic [npcm_pkg::CHAN_W-1:0]   r;
		logic [npcm_pkg::CHAN_W-1:0]   g;
		logic [npcm_pkg::CHAN_W-1:0]   b;
		logic [npcm_pkg::COUNT_W-1:0]  cnt;
		logic                          typed;
		logic [npcm_pkg::INDEX_W-1:0]  exp_idx;
		logic [npcm_pkg::DIST_W-1:0]   exp_dist;
	} stim_row_t;

	typedef struct {
		logic [npcm_pkg::INDEX_W-1:0] color_index;
		logic [npcm_pkg::DIST_W-1:0]  distance;
	} match_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic                          op = npcm_pkg::OP_WRITE;
	logic [npcm_pkg::INDEX_W-1:0]  entry_index = '0;
	logic [npcm_pkg::CHAN_W-1:0]   red = '0;
	logic [npcm_pkg::CHAN_W-1:0]   green = '0;
	logic [npcm_pkg::CHAN_W-1:0]   blue = '0;
	logic                          cfg_wr_en = 1'b0;
	logic [npcm_pkg::COUNT_W-1:0]  cfg_wr_data = '0;
	logic                          done;
	logic [npcm_pkg::INDEX_W-1:0]  color_index;
	logic [npcm_pkg::DIST_W-1:0]   distance;

	logic [npcm_pkg::CHAN_W-1:0]   palette_red   [npcm_pkg::PALETTE_DEPTH];
	logic [npcm_pkg::CHAN_W-1:0]   palette_green [npcm_pkg::PALETTE_DEPTH];
	logic [npcm_pkg::CHAN_W-1:0]   palette_blue  [npcm_pkg::PALETTE_DEPTH];
	bit                            entry_written [npcm_pkg::PALETTE_DEPTH];
	logic [npcm_pkg::COUNT_W-1:0]  palette_count = npcm_pkg::COUNT_RESET;
	match_t                        pending_matches [$];
	int                            failures = 0;
	int                            cycle_count = 0;

	stim_row_t directed_rows [0:17] = '{
		'{ROW_CFG, npcm_pkg::OP_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 9'd4, 1'b0, 8'd0, 18'd0},
		'{ROW_ITEM, npcm_pkg::OP_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0, 1'b0, 8'd0, 18'd0},
		'{ROW_ITEM, npcm_pkg::OP_WRITE, 8'd1, 8'd255, 8'd255, 8'd255, 9'd0, 1'b0, 8'd0, 18'd0},
		'{ROW_ITEM, npcm_pkg::OP_WRITE, 8'd2, 8'd255, 8'd0, 8'd0, 9'd0, 1'b0, 8'd0, 18'd0},
		'{ROW_ITEM, npcm_pkg::OP_WRITE, 8'd3, 8'd255, 8'd0, 8'd0, 9'd0, 1'b0, 8'd0, 18'd0},
		'{ROW_ITEM, npcm_pkg::OP_MAP, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0, 1'b1, 8'd0, 18'd0},
		'{ROW_ITEM, npcm_pkg::OP_MAP, 8'd0, 8'd255, 8'd255, 8'd255, 9'd0, 1'b1, 8'd1, 18'd0},
		'{ROW_ITEM, npcm_pkg::OP_MAP, 8'd0, 8'd255, 8'd0, 8'd0, 9'd0, 1'b1, 8'd2, 18'd0},
		'{ROW_ITEM, npcm_pkg::OP_MAP, 8'd0, 8'd0, 8'd255, 8'd255, 9'd0, 1'b1, 8'd1, 18'd65025},
		'{ROW_ITEM, npcm_pkg::OP_MAP, 8'd0, 8'd128, 8'd128, 8'd128, 9'd0, 1'b0, 8'd0, 18'd0},
		'{ROW_CFG, npcm_pkg::OP_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0, 1'b0, 8'd0, 18'd0},
		'{ROW_ITEM, npcm_pkg::OP_MAP, 8'd0, 8'd255, 8'd255, 8'd255, 9'd0, 1'b1, 8'd0, 18'd195075},
		'{ROW_CFG, npcm_pkg::OP_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 9'd1, 1'b0, 8'd0, 18'd0},
		'{ROW_ITEM, npcm_pkg::OP_MAP, 8'd0, 8'd0, 8'd255, 8'd255, 9'd0, 1'b1, 8'd0, 18'd130050},
		'{ROW_ITEM, npcm_pkg::OP_MAP, 8'd255, 8'd12, 8'd34, 8'd56, 9'd0, 1'b0, 8'd0, 18'd0},
		'{ROW_CFG, npcm_pkg::OP_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 9'd4, 1'b0, 8'd0, 18'd0},
		'{ROW_ITEM, npcm_pkg::OP_WRITE, 8'd3, 8'd1, 8'd2, 8'd3, 9'd0, 1'b0, 8'd0, 18'd0},
		'{ROW_ITEM, npcm_pkg::OP_MAP, 8'd0, 8'd1, 8'd2, 8'd4, 9'd0, 1'b1, 8'd3, 18'd1}
	};

	nearest_palette_color_mapper_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.done        (done),
		.color_index (color_index),
		.distance    (distance)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned searched_entries();
		if (palette_count == 0)
			return 1;
		if (palette_count > npcm_pkg::PALETTE_DEPTH)
			return npcm_pkg::PALETTE_DEPTH;
		return palette_count;
	endfunction

	function automatic int unsigned channel_gap_sq(input logic [npcm_pkg::CHAN_W-1:0] a,
			input logic [npcm_pkg::CHAN_W-1:0] b);
		int unsigned d;
		d = (a >= b) ? (a - b) : (b - a);
		return d * d;
	endfunction

	function automatic void find_nearest(input logic [npcm_pkg::CHAN_W-1:0] r,
			input logic [npcm_pkg::CHAN_W-1:0] g, input logic [npcm_pkg::CHAN_W-1:0] b,
			output match_t m);
		int unsigned best_dist;
		int unsigned d;
		int unsigned best_k;
		best_k = 0;
		best_dist = channel_gap_sq(palette_red[0], r) + channel_gap_sq(palette_green[0], g)
			+ channel_gap_sq(palette_blue[0], b);
		for (int unsigned k = 1; k < searched_entries(); k++) begin
			d = channel_gap_sq(palette_red[k], r) + channel_gap_sq(palette_green[k], g)
				+ channel_gap_sq(palette_blue[k], b);
			if (d < best_dist) begin
				best_dist = d;
				best_k = k;
			end
		end
		m.color_index = best_k[npcm_pkg::INDEX_W-1:0];
		m.distance = best_dist[npcm_pkg::DIST_W-1:0];
	endfunction

	function automatic logic [npcm_pkg::CHAN_W-1:0] pick_channel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return npcm_pkg::CHAN_W'($urandom_range(255));
		endcase
	endfunction

	task automatic issue_item(input npcm_pkg::op_t o, input logic [npcm_pkg::INDEX_W-1:0] idx,
			input logic [npcm_pkg::CHAN_W-1:0] r, input logic [npcm_pkg::CHAN_W-1:0] g,
			input logic [npcm_pkg::CHAN_W-1:0] b, input logic typed, input match_t typed_match,
			input int idle_pct);
		match_t m;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		entry_index <= idx;
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (o == npcm_pkg::OP_WRITE) begin
			palette_red[idx] = r;
			palette_green[idx] = g;
			palette_blue[idx] = b;
			entry_written[idx] = 1'b1;
		end else begin
			find_nearest(r, g, b, m);
			if (typed)
				m = typed_match;
			pending_matches = {pending_matches, m};
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_count(input logic [npcm_pkg::COUNT_W-1:0] value);
		wait_drained();
		repeat (npcm_pkg::LATENCY + 4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		palette_count = value;
	endtask

	task automatic fill_palette(input int idle_pct);
		match_t none;
		none = '{default: '0};
		for (int unsigned k = 0; k < searched_entries(); k++)
			if (!entry_written[k])
				issue_item(npcm_pkg::OP_WRITE, npcm_pkg::INDEX_W'(k), pick_channel(),
					pick_channel(), pick_channel(), 1'b0, none, idle_pct);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_matches.size() == 0) begin
				$error("result with no item pending: color_index %0d distance %0d",
					color_index, distance);
				failures++;
			end else begin
				if (color_index !== pending_matches[0].color_index) begin
					$error("color_index expected %0d actual %0d",
						pending_matches[0].color_index, color_index);
					failures++;
				end
				if (distance !== pending_matches[0].distance) begin
					$error("distance expected %0d actual %0d",
						pending_matches[0].distance, distance);
					failures++;
				end
				void'(pending_matches.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("nearest_palette_color_mapper_unit_test: FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned phase_setting [NUM_PHASES];
		int idle_pct;
		int unsigned k;
		match_t typed_match;
		match_t none;
		logic [npcm_pkg::CHAN_W-1:0] r, g, b;

		phase_setting = '{256, 1, 511, 0, 2, 257, 0, 100};
		phase_setting[6] = $urandom_range(3, 255);
		none = '{default: '0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				write_count(directed_rows[i].cnt);
			end else begin
				typed_match.color_index = directed_rows[i].exp_idx;
				typed_match.distance = directed_rows[i].exp_dist;
				issue_item(directed_rows[i].op_code, directed_rows[i].idx, directed_rows[i].r,
					directed_rows[i].g, directed_rows[i].b, directed_rows[i].typed,
					typed_match, 27);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			idle_pct = (ph < 3) ? 27 : (ph < 6) ? 69 : 0;
			write_count(npcm_pkg::COUNT_W'(phase_setting[ph]));
			fill_palette(idle_pct);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == PHASE_ITEMS / 2)
					wait_drained();
				r = pick_channel();
				g = pick_channel();
				b = pick_channel();
				if ($urandom_range(3) == 0) begin
					k = $urandom_range(searched_entries() - 1);
					r = palette_red[k];
					g = palette_green[k];
					b = palette_blue[k];
				end
				if ($urandom_range(99) < 35) begin
					k = ($urandom_range(3) == 0) ? $urandom_range(npcm_pkg::PALETTE_DEPTH - 1)
						: $urandom_range(searched_entries() - 1);
					issue_item(npcm_pkg::OP_WRITE, npcm_pkg::INDEX_W'(k), r, g, b, 1'b0, none,
						idle_pct);
				end else begin
					if ($urandom_range(2) == 0)
						r[0] = ~r[0];
					issue_item(npcm_pkg::OP_MAP, npcm_pkg::INDEX_W'($urandom_range(255)),
						r, g, b, 1'b0, none, idle_pct);
				end
			end
		end

		wait_drained();
		repeat (npcm_pkg::LATENCY + 8) @(posedge clk);
		if (failures == 0 && pending_matches.size() == 0) begin
			$display("nearest_palette_color_mapper_unit_test: PASS");
		end else begin
			$display("nearest_palette_color_mapper_unit_test: FAIL");
		end
		$finish;
	end

endmodule

FILE: nearest_palette_color_mapper_unit.f
rtl/npcm_pkg.sv
rtl/npcm_dist.sv
rtl/npcm_cell.sv
rtl/nearest_palette_color_mapper_unit.sv
sim/nearest_palette_color_mapper_unit_test.sv
